// ===== design/wcp_pkg.sv =====
// Package with shared widths, payload types and helpers of the waveform centroid unit.
package wcp_pkg;

  localparam int MAX_SAMPLES = 256;

  // Sample index saturates at MAX_SAMPLES, so it needs room for that value.
  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);

  localparam longint unsigned SUM_MAX = 64'(255) * 64'(MAX_SAMPLES);
  localparam longint unsigned MOM_MAX =
      64'(255) * 64'(MAX_SAMPLES) * 64'(MAX_SAMPLES - 1) / 64'd2;

  localparam int SUM_W = $clog2(SUM_MAX + 1) + 1;
  localparam int MOM_W = $clog2(MOM_MAX + 1) + 1;

  localparam int Q8_SHIFT = 8;
  // Unsigned magnitude of moment * 256.
  localparam int MAG_W = MOM_W + Q8_SHIFT;
  // Wide enough to compare against the 32-bit saturation limits.
  localparam int QW = (MAG_W > 33) ? MAG_W : 33;
  localparam int CNT_W = $clog2(MAG_W + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] BYTE_MASK = 8'hff;

  typedef struct packed {
    logic [7:0] raw_sample;
    logic [7:0] bias_raw;
    logic       last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] centroid_q8;
    logic [7:0]         peak_value;
    logic               zero_sum;
  } result_t;

  // One finished waveform handed from the front to the divider.
  typedef struct packed {
    logic signed [MOM_W-1:0] moment;
    logic signed [SUM_W-1:0] sum;
    logic [7:0]              peak;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Conditioned sample: inverted raw minus inverted bias, -255..255.
  function automatic logic signed [8:0] condition(input logic [7:0] raw,
                                                  input logic [7:0] bias);
    logic signed [8:0] a;
    logic signed [8:0] b;
    a = $signed({1'b0, ~raw & BYTE_MASK});
    b = $signed({1'b0, ~bias & BYTE_MASK});
    return a - b;
  endfunction

endpackage

// ===== design/waveform_centroid_peak_unit.sv =====
// Top level: sample accumulator, job queue and serial centroid divider.
// Throughput: one sample per cycle; the front stalls only when both queue slots are full.
// Result path: the job passes through the queue, then the one-bit-per-cycle divider (ST_DIV),
// saturation (ST_SAT) and the result register (ST_DONE); a zero-sum waveform skips to ST_DONE.
// Waveforms shorter than the divider time fill the two-entry queue and then see full.
// Reset is asynchronous, active low: accumulators, queue pointers and divider state clear at once.
module waveform_centroid_peak_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  wcp_pkg::sample_t in_i,
  output logic             empty,
  input  logic             pop,
  output wcp_pkg::result_t result_o
);
  import wcp_pkg::*;

  job_t         front_job;
  logic         front_push;
  job_t         queue_job;
  logic         back_pop;
  fifo_status_t queue_status;

  wcp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_i       (in_i),
    .job_full_i (queue_status.full),
    .job_push_o (front_push),
    .job_o      (front_job)
  );

  wcp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (front_push),
    .data_i   (front_job),
    .pop_i    (back_pop),
    .data_o   (queue_job),
    .status_o (queue_status)
  );

  wcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_status_i (queue_status),
    .job_i        (queue_job),
    .job_pop_o    (back_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .result_o     (result_o)
  );

  // A zero-sum waveform always reports a zero centroid.
  a_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.zero_sum) |-> (result_o.centroid_q8 == 32'sd0))
    else $error("zero_sum result with nonzero centroid");

  // The queue only fills up right after the last beat of a waveform.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && in_i.last_sample))
    else $error("queue became full without a last-sample beat");

endmodule

// ===== design/wcp_front.sv =====
// Front end: conditions samples and accumulates sum, first moment and peak per waveform.
module wcp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  wcp_pkg::sample_t  in_i,
  input  logic              job_full_i,
  output logic              job_push_o,
  output wcp_pkg::job_t     job_o
);
  import wcp_pkg::*;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [MOM_W-1:0] mom_q, mom_d;
  logic [7:0]              peak_q, peak_d;
  logic [IDX_W-1:0]        idx_q, idx_d;

  logic signed [8:0]        v;
  logic signed [IDX_W+9:0]  prod;
  logic                     in_range;
  logic                     accept;
  logic signed [SUM_W-1:0]  sum_n;
  logic signed [MOM_W-1:0]  mom_n;
  logic [7:0]               peak_n;
  logic [IDX_W-1:0]         idx_n;

  assign full_o = job_full_i;
  assign accept = push_i && !job_full_i;

  always_comb begin
    v        = condition(in_i.raw_sample, in_i.bias_raw);
    prod     = v * $signed({1'b0, idx_q});
    in_range = idx_q < IDX_W'(MAX_SAMPLES);
    sum_n    = sum_q;
    mom_n    = mom_q;
    peak_n   = peak_q;
    idx_n    = idx_q;
    if (in_range) begin
      sum_n = sum_q + SUM_W'(v);
      mom_n = mom_q + MOM_W'(prod);
      if (v >= $signed({1'b0, peak_q})) begin
        peak_n = v[7:0];
      end
      idx_n = idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    sum_d  = sum_q;
    mom_d  = mom_q;
    peak_d = peak_q;
    idx_d  = idx_q;
    if (accept) begin
      if (in_i.last_sample) begin
        sum_d  = '0;
        mom_d  = '0;
        peak_d = '0;
        idx_d  = '0;
      end else begin
        sum_d  = sum_n;
        mom_d  = mom_n;
        peak_d = peak_n;
        idx_d  = idx_n;
      end
    end
  end

  assign job_push_o   = accept && in_i.last_sample;
  assign job_o.moment = mom_n;
  assign job_o.sum    = sum_n;
  assign job_o.peak   = peak_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      mom_q  <= '0;
      peak_q <= '0;
      idx_q  <= '0;
    end else begin
      sum_q  <= sum_d;
      mom_q  <= mom_d;
      peak_q <= peak_d;
      idx_q  <= idx_d;
    end
  end

endmodule

// ===== design/wcp_fifo.sv =====
// Short job queue between the accumulating front and the dividing back end.
module wcp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  wcp_pkg::job_t         data_i,
  input  logic                  pop_i,
  output wcp_pkg::job_t         data_o,
  output wcp_pkg::fifo_status_t status_o
);
  import wcp_pkg::*;

  job_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [PTR_W-1:0]  rd_q, rd_d;
  logic [FCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign status_o.full  = cnt_q == FCNT_W'(FIFO_DEPTH);
  assign status_o.empty = cnt_q == '0;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/wcp_back.sv =====
// Back end: serial divider for moment*256/sum, saturation and the result register.
module wcp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wcp_pkg::fifo_status_t job_status_i,
  input  wcp_pkg::job_t         job_i,
  output logic                  job_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output wcp_pkg::result_t      result_o
);
  import wcp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] quo_q, quo_d;
  logic [SUM_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] div_q, div_d;
  logic             neg_q, neg_d;
  result_t          res_q, res_d;

  logic [MOM_W-1:0] mom_mag;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W:0]   rem_sh;
  logic             ge;
  logic [QW-1:0]    qext;
  logic [31:0]      qlow;

  assign empty_o   = state_q != ST_DONE;
  assign result_o  = res_q;
  assign job_pop_o = (state_q == ST_IDLE) && !job_status_i.empty;

  always_comb begin
    mom_mag = job_i.moment[MOM_W-1] ? MOM_W'(-job_i.moment) : MOM_W'(job_i.moment);
    sum_mag = job_i.sum[SUM_W-1] ? SUM_W'(-job_i.sum) : SUM_W'(job_i.sum);
    rem_sh  = {rem_q, quo_q[MAG_W-1]};
    ge      = rem_sh >= {1'b0, div_q};
    qext    = QW'(quo_q);
    qlow    = qext[31:0];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    neg_d   = neg_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (!job_status_i.empty) begin
          res_d.peak_value = job_i.peak;
          res_d.zero_sum   = job_i.sum == '0;
          quo_d = {mom_mag, {Q8_SHIFT{1'b0}}};
          rem_d = '0;
          div_d = sum_mag;
          neg_d = job_i.moment[MOM_W-1] ^ job_i.sum[SUM_W-1];
          cnt_d = CNT_W'(MAG_W);
          if (job_i.sum == '0) begin
            res_d.centroid_q8 = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // restoring step: one quotient bit per cycle, MSB first
        rem_d = ge ? SUM_W'(rem_sh - {1'b0, div_q}) : rem_sh[SUM_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        if (neg_q) begin
          if (qext > QW'(33'h0_8000_0000)) begin
            res_d.centroid_q8 = 32'sh8000_0000;
          end else begin
            res_d.centroid_q8 = $signed(-qlow);
          end
        end else begin
          if (qext > QW'(33'h0_7fff_ffff)) begin
            res_d.centroid_q8 = 32'sh7fff_ffff;
          end else begin
            res_d.centroid_q8 = $signed(qlow);
          end
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (pop_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
